// ===== rtl/gpio_pkg.sv =====
// ----------------------------------------------------------------------------
// gpio_pkg: shared types and constants of the GPIO port
// Register select codes, transaction kinds, pad register slots and the
// interrupt configuration bundle.
// ----------------------------------------------------------------------------
package gpio_pkg;

   localparam int DATA_W = 8;
   localparam int SEL_W  = 5;
   localparam int PAD_W  = 3;

   typedef logic [DATA_W-1:0] byte_type;

   // Transaction kind carried by every request
   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_READ  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   // Register map
   localparam logic [SEL_W-1:0] REG_DATA      = 5'd0;
   localparam logic [SEL_W-1:0] REG_DIR       = 5'd1;
   localparam logic [SEL_W-1:0] REG_SENSE     = 5'd2;
   localparam logic [SEL_W-1:0] REG_BOTH      = 5'd3;
   localparam logic [SEL_W-1:0] REG_EVENT     = 5'd4;
   localparam logic [SEL_W-1:0] REG_ENABLE    = 5'd5;
   localparam logic [SEL_W-1:0] REG_RAW       = 5'd6;
   localparam logic [SEL_W-1:0] REG_MASKED    = 5'd7;
   localparam logic [SEL_W-1:0] REG_CLEAR     = 5'd8;
   localparam logic [SEL_W-1:0] REG_PAD_FIRST = 5'd9;
   localparam logic [SEL_W-1:0] REG_PAD_LAST  = 5'd16;

   // Pad register slots with a function beyond storage
   localparam int PAD_REGS       = 8;
   localparam int PAD_OPEN_DRAIN = 2;
   localparam int PAD_DIGITAL_EN = 7;

   // Interrupt mode bits handed to the detector
   typedef struct packed {
      byte_type level_sense;
      byte_type both_edges;
      byte_type event_polarity;
   } irq_cfg_type;

endpackage

// ===== rtl/gpio_req_if.sv =====
// ----------------------------------------------------------------------------
// gpio_req_if: request channel of the GPIO port
// Valid/ready handshake carrying a tick, a bus read, a bus write or a no-op.
// ----------------------------------------------------------------------------
interface gpio_req_if;
   logic                 valid;
   logic                 ready;
   gpio_pkg::action_type action;
   logic [4:0]           reg_sel;
   logic [7:0]           access_mask;
   logic [7:0]           write_data;
   logic [7:0]           pin_levels;

   modport source (
      output valid, action, reg_sel, access_mask, write_data, pin_levels,
      input  ready
   );
   modport sink (
      input  valid, action, reg_sel, access_mask, write_data, pin_levels,
      output ready
   );
endinterface

// ===== rtl/gpio_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gpio_rsp_if: response channel of the GPIO port
// Valid/ready handshake carrying read data and the pad/interrupt outputs.
// ----------------------------------------------------------------------------
interface gpio_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [7:0] pin_drive;
   logic [7:0] pin_drive_enable;
   logic       interrupt_request;

   modport source (
      output valid, read_data, pin_drive, pin_drive_enable, interrupt_request,
      input  ready
   );
   modport sink (
      input  valid, read_data, pin_drive, pin_drive_enable, interrupt_request,
      output ready
   );
endinterface

// ===== rtl/gpio_irq_detect.sv =====
// ----------------------------------------------------------------------------
// gpio_irq_detect: per-pin interrupt status update on a tick
// Level pins follow the selected level; edge pins latch rising, falling or
// any change until cleared.
// ----------------------------------------------------------------------------
module gpio_irq_detect (
   input  gpio_pkg::byte_type    levels,
   input  gpio_pkg::byte_type    prev_levels,
   input  gpio_pkg::byte_type    raw_status,
   input  gpio_pkg::irq_cfg_type cfg,
   output gpio_pkg::byte_type    raw_next
);
   import gpio_pkg::*;

   byte_type rise;
   byte_type fall;
   byte_type edge_hit;
   byte_type level_hit;

   // edge detection against the previous sample
   assign rise = levels & ~prev_levels;
   assign fall = ~levels & prev_levels;

   assign edge_hit = (cfg.both_edges & (rise | fall))
                   | (~cfg.both_edges & cfg.event_polarity & rise)
                   | (~cfg.both_edges & ~cfg.event_polarity & fall);

   // level mode: status equals match of level and polarity
   assign level_hit = ~(levels ^ cfg.event_polarity);

   // edge bits are sticky, level bits are recomputed
   assign raw_next = ((raw_status | edge_hit) & ~cfg.level_sense)
                   | (level_hit & cfg.level_sense);

endmodule

// ===== rtl/gpio_port_with_pin_interrupts_unit.sv =====
// ----------------------------------------------------------------------------
// gpio_port_with_pin_interrupts_unit: GPIO port with per-pin interrupts
// The response is valid in the cycle after request acceptance.
// Throughput: one transaction per cycle; the response register decouples
// the sides, so a request is taken whenever the response slot is free or
// being drained in the same cycle.
// Reset: synchronous; state, pad settings and status clear; payload holds.
// ----------------------------------------------------------------------------
module gpio_port_with_pin_interrupts_unit #(
   parameter int PIN_COUNT = 8
) (
   input  logic       clock,
   input  logic       reset,
   gpio_req_if.sink   req_if,
   gpio_rsp_if.source rsp_if
);
   import gpio_pkg::*;

   localparam byte_type LIVE_PINS = (PIN_COUNT >= DATA_W) ? {DATA_W{1'b1}} :
                                    DATA_W'((64'd1 << PIN_COUNT) - 64'd1);

   // architectural state
   byte_type output_latch_ff,    output_latch_in;
   byte_type direction_ff,       direction_in;
   byte_type level_sense_ff,     level_sense_in;
   byte_type both_edges_ff,      both_edges_in;
   byte_type event_polarity_ff,  event_polarity_in;
   byte_type irq_enable_ff,      irq_enable_in;
   byte_type raw_status_ff,      raw_status_in;
   byte_type prev_levels_ff,     prev_levels_in;
   byte_type pad_ff [PAD_REGS];
   logic     pad_we;

   // response register
   logic     rsp_valid_ff,       rsp_valid_in;
   byte_type read_data_ff,       read_data_in;
   byte_type pin_drive_ff,       pin_drive_in;
   byte_type drive_enable_ff,    drive_enable_in;
   logic     irq_ff,             irq_in;

   logic        accept;
   byte_type    wr_val;
   byte_type    levels;
   byte_type    raw_tick;
   irq_cfg_type irq_cfg;
   logic [SEL_W-1:0] pad_off;
   logic [PAD_W-1:0] pad_idx;

   // handshake
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign wr_val  = req_if.write_data & LIVE_PINS;
   assign levels  = req_if.pin_levels & LIVE_PINS;
   assign pad_off = req_if.reg_sel - REG_PAD_FIRST;
   assign pad_idx = pad_off[PAD_W-1:0];

   // interrupt status update on tick
   assign irq_cfg = '{level_sense:    level_sense_ff,
                      both_edges:     both_edges_ff,
                      event_polarity: event_polarity_ff};

   gpio_irq_detect u_irq_detect (
      .levels      (levels),
      .prev_levels (prev_levels_ff),
      .raw_status  (raw_status_ff),
      .cfg         (irq_cfg),
      .raw_next    (raw_tick)
   );

   // next state for ticks and bus writes
   always_comb begin
      output_latch_in   = output_latch_ff;
      direction_in      = direction_ff;
      level_sense_in    = level_sense_ff;
      both_edges_in     = both_edges_ff;
      event_polarity_in = event_polarity_ff;
      irq_enable_in     = irq_enable_ff;
      raw_status_in     = raw_status_ff;
      prev_levels_in    = prev_levels_ff;
      pad_we            = 1'b0;
      if (accept && req_if.action == ACT_TICK) begin
         raw_status_in  = raw_tick & LIVE_PINS;
         prev_levels_in = levels;
      end else if (accept && req_if.action == ACT_WRITE) begin
         unique case (req_if.reg_sel) inside
            REG_DATA: begin
               output_latch_in = (output_latch_ff & ~(req_if.access_mask & LIVE_PINS))
                               | (wr_val & req_if.access_mask);
            end
            REG_DIR:    direction_in      = wr_val;
            REG_SENSE:  level_sense_in    = wr_val;
            REG_BOTH:   both_edges_in     = wr_val;
            REG_EVENT:  event_polarity_in = wr_val;
            REG_ENABLE: irq_enable_in     = wr_val;
            REG_CLEAR:  raw_status_in     = raw_status_ff & ~wr_val;
            [REG_PAD_FIRST:REG_PAD_LAST]: pad_we = 1'b1;
            default: ;
         endcase
      end
   end

   // bus read decode, from state before the transaction
   always_comb begin
      read_data_in = '0;
      if (req_if.action == ACT_READ) begin
         unique case (req_if.reg_sel) inside
            REG_DATA: begin
               read_data_in = ((direction_ff & output_latch_ff)
                             | (~direction_ff & prev_levels_ff & pad_ff[PAD_DIGITAL_EN]))
                             & req_if.access_mask & LIVE_PINS;
            end
            REG_DIR:    read_data_in = direction_ff;
            REG_SENSE:  read_data_in = level_sense_ff;
            REG_BOTH:   read_data_in = both_edges_ff;
            REG_EVENT:  read_data_in = event_polarity_ff;
            REG_ENABLE: read_data_in = irq_enable_ff;
            REG_RAW:    read_data_in = raw_status_ff;
            REG_MASKED: read_data_in = raw_status_ff & irq_enable_ff;
            [REG_PAD_FIRST:REG_PAD_LAST]: read_data_in = pad_ff[pad_idx];
            default:    read_data_in = '0;
         endcase
      end
   end

   // pad outputs and interrupt line, from state after the transaction
   always_comb begin
      byte_type od_in;
      od_in = (pad_we && pad_idx == PAD_W'(PAD_OPEN_DRAIN)) ? wr_val
                                                            : pad_ff[PAD_OPEN_DRAIN];
      pin_drive_in    = output_latch_in;
      drive_enable_in = direction_in & ~(od_in & output_latch_in) & LIVE_PINS;
      irq_in          = |(raw_status_in & irq_enable_in);
   end

   // response slot occupancy
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         output_latch_ff   <= '0;
         direction_ff      <= '0;
         level_sense_ff    <= '0;
         both_edges_ff     <= '0;
         event_polarity_ff <= '0;
         irq_enable_ff     <= '0;
         raw_status_ff     <= '0;
         prev_levels_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         output_latch_ff   <= output_latch_in;
         direction_ff      <= direction_in;
         level_sense_ff    <= level_sense_in;
         both_edges_ff     <= both_edges_in;
         event_polarity_ff <= event_polarity_in;
         irq_enable_ff     <= irq_enable_in;
         raw_status_ff     <= raw_status_in;
         prev_levels_ff    <= prev_levels_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // pad settings file
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAD_REGS; i++) begin
            pad_ff[i] <= '0;
         end
      end else if (pad_we) begin
         pad_ff[pad_idx] <= wr_val;
      end
   end

   // response payload, loaded on acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         read_data_ff    <= read_data_in;
         pin_drive_ff    <= pin_drive_in;
         drive_enable_ff <= drive_enable_in;
         irq_ff          <= irq_in;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.read_data         = read_data_ff;
   assign rsp_if.pin_drive         = pin_drive_ff;
   assign rsp_if.pin_drive_enable  = drive_enable_ff;
   assign rsp_if.interrupt_request = irq_ff;

endmodule

// ===== tb/gpio_port_with_pin_interrupts_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpio_port_with_pin_interrupts_unit_tb: self-checking bench for the GPIO port
// A short directed table opens the run: reset values, masked data access,
// open drain, digital enable, edge and level interrupts, write-one-to-clear
// and the ignored selects. Random ticks, reads and writes follow. A local
// model predicts the untyped responses. Both channels idle at random.
// ----------------------------------------------------------------------------
module gpio_port_with_pin_interrupts_unit_tb;
   import gpio_pkg::*;

   localparam int RANDOM_ITEMS = 1125;
   localparam int DRAIN_POINT  = 560;

   // One response as seen on the result channel
   typedef struct packed {
      byte_type rd;
      byte_type drive;
      byte_type drive_en;
      logic     irq;
   } port_out_type;

   // One row of the directed table
   typedef struct {
      action_type   act;
      logic [4:0]   sel;
      byte_type     mask;
      byte_type     wdata;
      byte_type     levels;
      bit           typed;
      port_out_type want;
   } step_type;

   logic clock;
   logic reset;

   gpio_req_if req_if ();
   gpio_rsp_if rsp_if ();

   gpio_port_with_pin_interrupts_unit #(.PIN_COUNT(8)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Local copy of the port state
   byte_type out_latch, pin_dir, sense_lvl, edge_both, polarity, irq_en;
   byte_type irq_raw, last_levels;
   byte_type pad_cfg [PAD_REGS];

   port_out_type port_outputs_due [$];
   step_type     steps [$];
   int           mismatches = 0;
   int           steady_items;
   int           stall_left = 0;
   int           calm_left = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Report one mismatch and count it
   task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
      mismatches++;
   endtask

   // Apply one transaction to the local state and return the port outputs
   function automatic port_out_type port_response(action_type act, logic [4:0] sel,
                                                  byte_type mask, byte_type wdata,
                                                  byte_type levels);
      port_out_type o;
      byte_type     rise, fall, hit, lvl;
      o.rd = '0;
      case (act)
         ACT_TICK: begin
            rise    = levels & ~last_levels;
            fall    = ~levels & last_levels;
            hit     = (edge_both & (rise | fall)) | (~edge_both & polarity & rise)
                    | (~edge_both & ~polarity & fall);
            lvl     = ~(levels ^ polarity);
            irq_raw = ((irq_raw | hit) & ~sense_lvl) | (lvl & sense_lvl);
            last_levels = levels;
         end
         ACT_READ: begin
            case (sel)
               REG_DATA:   o.rd = ((pin_dir & out_latch)
                                 | (~pin_dir & last_levels & pad_cfg[PAD_DIGITAL_EN]))
                                 & mask;
               REG_DIR:    o.rd = pin_dir;
               REG_SENSE:  o.rd = sense_lvl;
               REG_BOTH:   o.rd = edge_both;
               REG_EVENT:  o.rd = polarity;
               REG_ENABLE: o.rd = irq_en;
               REG_RAW:    o.rd = irq_raw;
               REG_MASKED: o.rd = irq_raw & irq_en;
               default:
                  if (sel >= REG_PAD_FIRST && sel <= REG_PAD_LAST)
                     o.rd = pad_cfg[PAD_W'(sel - REG_PAD_FIRST)];
            endcase
         end
         ACT_WRITE: begin
            case (sel)
               REG_DATA:   out_latch = (out_latch & ~mask) | (wdata & mask);
               REG_DIR:    pin_dir   = wdata;
               REG_SENSE:  sense_lvl = wdata;
               REG_BOTH:   edge_both = wdata;
               REG_EVENT:  polarity  = wdata;
               REG_ENABLE: irq_en    = wdata;
               REG_CLEAR:  irq_raw   = irq_raw & ~wdata;
               default:
                  if (sel >= REG_PAD_FIRST && sel <= REG_PAD_LAST)
                     pad_cfg[PAD_W'(sel - REG_PAD_FIRST)] = wdata;
            endcase
         end
         default: ;
      endcase
      o.drive    = out_latch;
      o.drive_en = pin_dir & ~(pad_cfg[PAD_OPEN_DRAIN] & out_latch);
      o.irq      = |(irq_raw & irq_en);
      return o;
   endfunction

   // Add one directed row; typed rows carry their own expectation
   task automatic row(action_type act, logic [4:0] sel, byte_type mask, byte_type wdata,
                      byte_type levels, bit typed, byte_type rd, byte_type drive,
                      byte_type drive_en, logic irq);
      step_type s;
      s.act    = act;
      s.sel    = sel;
      s.mask   = mask;
      s.wdata  = wdata;
      s.levels = levels;
      s.typed  = typed;
      s.want   = {rd, drive, drive_en, irq};
      steps.push_back(s);
   endtask

   // Present one transaction and wait for it to be taken; valid stays high
   task automatic send_item(action_type act, logic [4:0] sel, byte_type mask,
                            byte_type wdata, byte_type levels, bit typed,
                            port_out_type typed_want);
      port_out_type predicted;
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.reg_sel     <= sel;
      req_if.access_mask <= mask;
      req_if.write_data  <= wdata;
      req_if.pin_levels  <= levels;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = port_response(act, sel, mask, wdata, levels);
      port_outputs_due.push_back(typed ? typed_want : predicted);
   endtask

   // Sender gap: mostly none or short, a few long, with idle-free stretches
   function automatic int sender_gap();
      int r;
      if (steady_items > 0) begin
         steady_items--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) steady_items = $urandom_range(30, 80);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic hold_off(int n);
      if (n > 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Response side back-pressure
   always @(posedge clock) begin : rsp_drain
      int   r;
      logic take;
      take = 1'b1;
      if (calm_left > 0) begin
         calm_left--;
      end else if (stall_left > 0) begin
         stall_left--;
         take = 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 2) begin
            calm_left = $urandom_range(50, 150);
         end else if (r < 22) begin
            stall_left = $urandom_range(0, 2);
            take = 1'b0;
         end else if (r < 26) begin
            stall_left = $urandom_range(6, 40);
            take = 1'b0;
         end
      end
      rsp_if.ready <= take;
   end

   // Response checker
   always @(posedge clock) begin : rsp_check
      port_out_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (port_outputs_due.size() == 0) begin
            flag_mismatch("unexpected response, read_data", rsp_if.read_data, 8'h00);
         end else begin
            want = port_outputs_due.pop_front();
            if (rsp_if.read_data !== want.rd)
               flag_mismatch("read_data", rsp_if.read_data, want.rd);
            if (rsp_if.pin_drive !== want.drive)
               flag_mismatch("pin_drive", rsp_if.pin_drive, want.drive);
            if (rsp_if.pin_drive_enable !== want.drive_en)
               flag_mismatch("pin_drive_enable", rsp_if.pin_drive_enable, want.drive_en);
            if (rsp_if.interrupt_request !== want.irq)
               flag_mismatch("interrupt_request", {7'b0, rsp_if.interrupt_request},
                             {7'b0, want.irq});
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      action_type act;
      logic [4:0] sel;
      byte_type   mask, wdata, levels;
      int         r;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.action      = ACT_TICK;
      req_if.reg_sel     = '0;
      req_if.access_mask = '0;
      req_if.write_data  = '0;
      req_if.pin_levels  = '0;
      steady_items       = 0;
      out_latch = '0; pin_dir = '0; sense_lvl = '0; edge_both = '0;
      polarity  = '0; irq_en  = '0; irq_raw   = '0; last_levels = '0;
      foreach (pad_cfg[i]) pad_cfg[i] = '0;

      // Directed table
      // reset values, out-of-map selects and the no-op action
      row(ACT_READ,  REG_DATA,     8'hFF, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_READ,  REG_PAD_LAST, 8'hFF, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_READ,  5'd31,        8'hFF, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_NOP,   REG_DATA,     8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0);
      // outputs, masked latch write, open drain
      row(ACT_WRITE, REG_DIR,      8'h00, 8'hFF, 8'h00, 1'b1, 8'h00, 8'h00, 8'hFF, 1'b0);
      row(ACT_WRITE, REG_DATA,     8'h0F, 8'hFF, 8'h00, 1'b1, 8'h00, 8'h0F, 8'hFF, 1'b0);
      row(ACT_WRITE, 5'(REG_PAD_FIRST + PAD_OPEN_DRAIN), 8'h00, 8'hFF, 8'h00,
          1'b1, 8'h00, 8'h0F, 8'hF0, 1'b0);
      row(ACT_READ,  REG_DATA,     8'hFF, 8'h00, 8'h00, 1'b1, 8'h0F, 8'h0F, 8'hF0, 1'b0);
      row(ACT_WRITE, REG_DATA,     8'hF0, 8'hA5, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_WRITE, 5'(REG_PAD_FIRST + PAD_OPEN_DRAIN), 8'h00, 8'h00, 8'h00,
          1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      // inputs through digital enable
      row(ACT_WRITE, REG_DIR,      8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_WRITE, 5'(REG_PAD_FIRST + PAD_DIGITAL_EN), 8'h00, 8'hFF, 8'h00,
          1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_TICK,  REG_DATA,     8'h00, 8'h00, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_READ,  REG_DATA,     8'h3C, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      // falling edges raise status, writes to status ignored, clear by ones
      row(ACT_WRITE, REG_ENABLE,   8'h00, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_TICK,  REG_DATA,     8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_WRITE, REG_RAW,      8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_WRITE, REG_MASKED,   8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_READ,  REG_CLEAR,    8'hFF, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_WRITE, REG_CLEAR,    8'h00, 8'h0F, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      // level mode on low nibble, both edges on high nibble
      row(ACT_WRITE, REG_SENSE,    8'h00, 8'h0F, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_WRITE, REG_EVENT,    8'h00, 8'h33, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_WRITE, REG_BOTH,     8'h00, 8'hF0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_TICK,  REG_DATA,     8'h00, 8'h00, 8'h55, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_READ,  REG_MASKED,   8'hFF, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_WRITE, 5'd20,        8'hFF, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
      row(ACT_READ,  5'd17,        8'hFF, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[i]) begin
         send_item(steps[i].act, steps[i].sel, steps[i].mask, steps[i].wdata,
                   steps[i].levels, steps[i].typed, steps[i].want);
         hold_off(sender_gap());
      end

      // Random traffic: ticks that toggle one pin or jump, mixed with access
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(0, 99);
         if (r < 45)      act = ACT_TICK;
         else if (r < 72) act = ACT_WRITE;
         else if (r < 97) act = ACT_READ;
         else             act = ACT_NOP;
         sel   = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 16))
                                              : 5'($urandom_range(0, 31));
         mask  = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom);
         wdata = 8'($urandom);
         if ($urandom_range(0, 1) == 0)
            levels = 8'($urandom);
         else
            levels = last_levels ^ (8'h01 << $urandom_range(0, 7));
         send_item(act, sel, mask, wdata, levels, 1'b0, '0);
         if (n == DRAIN_POINT) begin
            // let the response side empty out completely
            req_if.valid <= 1'b0;
            @(posedge clock);
            while (port_outputs_due.size() != 0) @(posedge clock);
         end else begin
            hold_off(sender_gap());
         end
      end

      // Drain and finish
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (port_outputs_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
